/* design/medt_pkg.sv */
// shared constants, types and float compare helpers for the mesh edge dedup table
package medt_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_MAX_EDGES  = 4096;
  localparam int LANES          = 16;
  localparam int LOG_LANES      = 4;
  localparam int MODE_W         = 2;
  localparam int VTX_W          = 10;
  localparam int COORD_W        = 32;
  localparam int PT_W           = 3 * COORD_W;
  localparam int ENTRY_W        = 2 * VTX_W;
  localparam int IDX_OUT_W      = 12;

  localparam logic [MODE_W-1:0] MODE_POINT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRI   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTS,
    ST_ORIENT,
    ST_SEARCH,
    ST_DECIDE,
    ST_WRITE,
    ST_DONE
  } medt_state_t;

  // per lane match flags for the three triangle edges
  typedef struct packed {
    logic [2:0] fwd;
    logic [2:0] bwd;
  } lane_hit_t;

  function automatic logic fp_is_nan(input logic [COORD_W-1:0] a);
    fp_is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_eq(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    fp_eq = !fp_is_nan(a) && !fp_is_nan(b) &&
            ((a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)));
  endfunction

  function automatic logic fp_gt(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    logic r;
    if (fp_is_nan(a) || fp_is_nan(b) || fp_eq(a, b)) begin
      r = 1'b0;
    end else if (!a[31] && b[31]) begin
      r = 1'b1;
    end else if (a[31] && !b[31]) begin
      r = 1'b0;
    end else if (!a[31]) begin
      r = a[30:0] > b[30:0];
    end else begin
      r = a[30:0] < b[30:0];
    end
    fp_gt = r;
  endfunction

  // point layout is {x, y, z}; true when p is not lexicographically greater than q
  function automatic logic pt_not_greater(input logic [PT_W-1:0] p, input logic [PT_W-1:0] q);
    logic r;
    r = 1'b1;
    if (fp_gt(p[95:64], q[95:64])) begin
      r = 1'b0;
    end else if (fp_eq(p[95:64], q[95:64])) begin
      if (fp_gt(p[63:32], q[63:32])) begin
        r = 1'b0;
      end else if (fp_eq(p[63:32], q[63:32]) && fp_gt(p[31:0], q[31:0])) begin
        r = 1'b0;
      end
    end
    pt_not_greater = r;
  endfunction

endpackage

/* design/mesh_edge_dedup_table_unit.sv */
// top level of the mesh edge dedup table: point store, lane search, edge append, result
//
// Input channel (in_valid/in_ready) takes one beat per item: mode 0 writes a point,
// mode 1 checks a triangle, mode 2 empties the edge table, mode 3 is dropped.
// Output channel (out_valid/out_ready) returns one beat per mode 1 item.
// Point writes, clears and dropped beats give no result.
// A degenerate triangle goes straight to the done state and skips the other steps.
// Another triangle runs through three point store reads, one orientation compare,
// one pass over the edge table that reads one row of the 16 lane banks per cycle,
// a decide step and three append steps.
// A triangle refused on a full table skips the append steps.
// The block takes one item at a time: a new beat is accepted only in the idle state.
// The result sits in an output register, so the next item is accepted while it
// waits; a finished triangle holds until that register frees when out_ready is low.
// Reset (rst, synchronous) empties the edge table count and drops any result;
// point store and edge banks keep no reset and need no clearing pass.
module mesh_edge_dedup_table_unit #(
  parameter int MAX_POINTS = medt_pkg::DEF_MAX_POINTS,
  parameter int MAX_EDGES  = medt_pkg::DEF_MAX_EDGES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [medt_pkg::MODE_W-1:0]       mode,
  input  logic [medt_pkg::VTX_W-1:0]        point_slot,
  input  logic [medt_pkg::COORD_W-1:0]      coord_x,
  input  logic [medt_pkg::COORD_W-1:0]      coord_y,
  input  logic [medt_pkg::COORD_W-1:0]      coord_z,
  input  logic [medt_pkg::VTX_W-1:0]        vertex_a,
  input  logic [medt_pkg::VTX_W-1:0]        vertex_b,
  input  logic [medt_pkg::VTX_W-1:0]        vertex_c,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              degenerate,
  output logic                              table_full,
  output logic [medt_pkg::IDX_OUT_W-1:0]    edge_ab_index,
  output logic                              edge_ab_backward,
  output logic [medt_pkg::IDX_OUT_W-1:0]    edge_bc_index,
  output logic                              edge_bc_backward,
  output logic [medt_pkg::IDX_OUT_W-1:0]    edge_ca_index,
  output logic                              edge_ca_backward
);
  import medt_pkg::*;

  localparam int PAW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int IXW  = (CW > LOG_LANES) ? CW + 1 : LOG_LANES + 1;
  localparam int ROWS = (MAX_EDGES + LANES - 1) / LANES;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  medt_state_t state, state_next;

  logic [PT_W-1:0]        pmem [MAX_POINTS];
  logic [PT_W-1:0]        pt_rd;
  logic                   pt_oor;
  logic [VTX_W-1:0]       paddr_v;

  logic [2:0][VTX_W-1:0]  vtx;
  logic [2:0][VTX_W-1:0]  q_start;
  logic [2:0][VTX_W-1:0]  q_finish;
  logic [2:0][PT_W-1:0]   pts;
  logic [1:0]             pcnt;
  logic [2:0]             ng;

  logic [CW-1:0]          edge_count;
  logic [IXW-1:0]         count_ix;
  logic [IXW-1:0]         rows_used;
  logic [IXW-1:0]         srow;
  logic                   rd_pend;
  logic [RW-1:0]          row_q;

  logic [2:0]             m_found;
  logic [2:0]             m_bwd;
  logic [2:0][IXW-1:0]    m_idx;
  lane_hit_t [LANES-1:0]  hits;

  logic [2:0]             miss;
  logic [2:0][IXW-1:0]    eidx;
  logic [1:0]             wcnt;
  logic [IXW-1:0]         need;
  logic [IXW-1:0]         w_ix;
  logic [ENTRY_W-1:0]     w_data;
  logic                   w_en;

  logic                   res_deg;
  logic                   res_full;
  logic [2:0][IDX_OUT_W-1:0] res_idx;
  logic [2:0]             res_bwd;

  logic                   acc_in;
  logic                   is_degen;
  logic                   out_free;

  assign acc_in   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign is_degen = (vertex_a == vertex_b) || (vertex_a == vertex_c) || (vertex_b == vertex_c);

  // query edges ab, bc, ca
  assign q_start  = {vtx[2], vtx[1], vtx[0]};
  assign q_finish = {vtx[0], vtx[2], vtx[1]};

  assign count_ix  = IXW'(edge_count);
  assign rows_used = (count_ix + IXW'(LANES - 1)) >> LOG_LANES;

  // point store address walks a, b, c
  always_comb begin
    case (pcnt)
      2'd1:    paddr_v = vtx[1];
      2'd2:    paddr_v = vtx[2];
      default: paddr_v = vtx[0];
    endcase
  end

  // point store, written on a point beat, registered read
  always_ff @(posedge clk) begin
    if (acc_in && (mode == MODE_POINT) && (32'(point_slot) < MAX_POINTS)) begin
      pmem[PAW'(point_slot)] <= {coord_x, coord_y, coord_z};
    end
    pt_rd  <= pmem[PAW'(paddr_v)];
    pt_oor <= !(32'(paddr_v) < MAX_POINTS);
  end

  // append write for the current missing edge
  always_comb begin
    w_ix   = eidx[wcnt];
    w_en   = (state == ST_WRITE) && miss[wcnt];
    w_data = ng[wcnt] ? {q_start[wcnt], q_finish[wcnt]} : {q_finish[wcnt], q_start[wcnt]};
    need   = IXW'(!m_found[0]) + IXW'(!m_found[1]) + IXW'(!m_found[2]);
  end

  // search lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    medt_lane #(
      .ROWS (ROWS),
      .RW   (RW),
      .IXW  (IXW),
      .LANE (l)
    ) u_lane (
      .clk      (clk),
      .wr_en    (w_en && (w_ix[LOG_LANES-1:0] == LOG_LANES'(l))),
      .wr_row   (RW'(w_ix >> LOG_LANES)),
      .wr_data  (w_data),
      .rd_row   (RW'(srow)),
      .chk_row  (row_q),
      .count    (count_ix),
      .q_start  (q_start),
      .q_finish (q_finish),
      .hit      (hits[l])
    );
  end

  // merge of lane hits
  medt_merge #(
    .RW  (RW),
    .IXW (IXW)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .clear (acc_in),
    .take  (rd_pend),
    .row   (row_q),
    .hits  (hits),
    .found (m_found),
    .bwd   (m_bwd),
    .idx   (m_idx)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc_in && (mode == MODE_TRI)) begin
          state_next = is_degen ? ST_DONE : ST_PTS;
        end
      end
      ST_PTS: begin
        if (pcnt == 2'd3) begin
          state_next = ST_ORIENT;
        end
      end
      ST_ORIENT: state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (!(srow < rows_used) && !rd_pend) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ((count_ix + need) > IXW'(MAX_EDGES)) ? ST_DONE : ST_WRITE;
      end
      ST_WRITE: begin
        if (wcnt == 2'd2) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
      pcnt       <= '0;
      wcnt       <= '0;
      srow       <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          pcnt <= '0;
          srow <= '0;
          wcnt <= '0;
          if (acc_in && (mode == MODE_CLEAR)) begin
            edge_count <= '0;
          end
          if (acc_in && (mode == MODE_TRI)) begin
            vtx      <= {vertex_c, vertex_b, vertex_a};
            res_deg  <= is_degen;
            res_full <= 1'b0;
            res_idx  <= '0;
            res_bwd  <= '0;
          end
        end
        ST_PTS: begin
          pcnt <= pcnt + 2'd1;
          if (pcnt != 2'd0) begin
            pts[pcnt - 2'd1] <= pt_oor ? '0 : pt_rd;
          end
        end
        ST_ORIENT: begin
          ng[0] <= pt_not_greater(pts[0], pts[1]);
          ng[1] <= pt_not_greater(pts[1], pts[2]);
          ng[2] <= pt_not_greater(pts[2], pts[0]);
        end
        ST_SEARCH: begin
          rd_pend <= srow < rows_used;
          row_q   <= RW'(srow);
          if (srow < rows_used) begin
            srow <= srow + IXW'(1);
          end
        end
        ST_DECIDE: begin
          miss    <= ~m_found;
          eidx[0] <= m_found[0] ? m_idx[0] : count_ix;
          eidx[1] <= m_found[1] ? m_idx[1] : count_ix + IXW'(!m_found[0]);
          eidx[2] <= m_found[2] ? m_idx[2]
                     : count_ix + IXW'(!m_found[0]) + IXW'(!m_found[1]);
          if ((count_ix + need) > IXW'(MAX_EDGES)) begin
            res_full <= 1'b1;
          end
        end
        ST_WRITE: begin
          wcnt <= wcnt + 2'd1;
          res_idx[wcnt] <= IDX_OUT_W'(eidx[wcnt]);
          res_bwd[wcnt] <= miss[wcnt] ? !ng[wcnt] : m_bwd[wcnt];
          if (miss[wcnt]) begin
            edge_count <= edge_count + CW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            degenerate       <= res_deg;
            table_full       <= res_full;
            edge_ab_index    <= res_idx[0];
            edge_ab_backward <= res_bwd[0];
            edge_bc_index    <= res_idx[1];
            edge_bc_backward <= res_bwd[1];
            edge_ca_index    <= res_idx[2];
            edge_ca_backward <= res_bwd[2];
          end
        end
        default: ;
      endcase
    end
  end

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    IXW'(edge_count) <= IXW'(MAX_EDGES))
    else $error("edge count above table size");

  // a degenerate result carries no edges and no full flag
  a_degen_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !table_full && (edge_ab_index == '0) &&
    (edge_bc_index == '0) && (edge_ca_index == '0))
    else $error("degenerate result with edge data");

  // a full table result stores nothing
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !degenerate && !edge_ab_backward &&
    !edge_bc_backward && !edge_ca_backward)
    else $error("full table result with edge data");

  // row reads in flight only during the search pass
  a_pend_search: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_SEARCH) || $past(state == ST_SEARCH))
    else $error("row read outside search pass");

endmodule

/* design/medt_lane.sv */
// one search lane: an edge table bank and the compare against three query edges
module medt_lane #(
  parameter int ROWS = 256,
  parameter int RW   = 8,
  parameter int IXW  = 13,
  parameter int LANE = 0
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [RW-1:0]                         wr_row,
  input  logic [medt_pkg::ENTRY_W-1:0]          wr_data,
  input  logic [RW-1:0]                         rd_row,
  input  logic [RW-1:0]                         chk_row,
  input  logic [IXW-1:0]                        count,
  input  logic [2:0][medt_pkg::VTX_W-1:0]       q_start,
  input  logic [2:0][medt_pkg::VTX_W-1:0]       q_finish,
  output medt_pkg::lane_hit_t                   hit
);
  import medt_pkg::*;

  logic [ENTRY_W-1:0] mem [ROWS];
  logic [ENTRY_W-1:0] rd_data;
  logic [IXW-1:0]     ent_ix;
  logic               ent_ok;

  // bank storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    rd_data <= mem[rd_row];
  end

  // entry is live only below the fill count
  assign ent_ix = (IXW'(chk_row) << LOG_LANES) | IXW'(LANE);
  assign ent_ok = ent_ix < count;

  // compare both directions for each edge
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit.fwd[k] = ent_ok && (rd_data[ENTRY_W-1:VTX_W] == q_start[k]) &&
                   (rd_data[VTX_W-1:0] == q_finish[k]);
      hit.bwd[k] = ent_ok && (rd_data[ENTRY_W-1:VTX_W] == q_finish[k]) &&
                   (rd_data[VTX_W-1:0] == q_start[k]);
    end
  end

endmodule

/* design/medt_merge.sv */
// merge stage: folds lane hits of each row beat into per edge found, index and direction
module medt_merge #(
  parameter int RW  = 8,
  parameter int IXW = 13
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clear,
  input  logic                                   take,
  input  logic [RW-1:0]                          row,
  input  medt_pkg::lane_hit_t [medt_pkg::LANES-1:0] hits,
  output logic [2:0]                             found,
  output logic [2:0]                             bwd,
  output logic [2:0][IXW-1:0]                    idx
);
  import medt_pkg::*;

  logic [2:0]           row_found;
  logic [2:0]           row_bwd;
  logic [2:0][IXW-1:0]  row_idx;

  // a stored edge is unique, so at most one lane hits per edge and an or tree suffices
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_found[k] = 1'b0;
      row_bwd[k]   = 1'b0;
      row_idx[k]   = '0;
      for (int l = 0; l < LANES; l++) begin
        if (hits[l].fwd[k] || hits[l].bwd[k]) begin
          row_found[k] = 1'b1;
          row_bwd[k]   = row_bwd[k] | hits[l].bwd[k];
          row_idx[k]   = row_idx[k] | (IXW'(row) << LOG_LANES) | IXW'(l);
        end
      end
    end
  end

  // accumulate over the search pass
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= '0;
      bwd   <= '0;
      idx   <= '0;
    end else if (take) begin
      for (int k = 0; k < 3; k++) begin
        if (row_found[k]) begin
          found[k] <= 1'b1;
          bwd[k]   <= row_bwd[k];
          idx[k]   <= row_idx[k];
        end
      end
    end
  end

endmodule

/* tb/sv/medt_checker.sv */
// checker for the mesh edge dedup table: watches both channels, predicts results, compares
module medt_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [medt_pkg::MODE_W-1:0]    mode,
  input  logic [medt_pkg::VTX_W-1:0]     point_slot,
  input  logic [medt_pkg::COORD_W-1:0]   coord_x,
  input  logic [medt_pkg::COORD_W-1:0]   coord_y,
  input  logic [medt_pkg::COORD_W-1:0]   coord_z,
  input  logic [medt_pkg::VTX_W-1:0]     vertex_a,
  input  logic [medt_pkg::VTX_W-1:0]     vertex_b,
  input  logic [medt_pkg::VTX_W-1:0]     vertex_c,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           degenerate,
  input  logic                           table_full,
  input  logic [medt_pkg::IDX_OUT_W-1:0] edge_ab_index,
  input  logic                           edge_ab_backward,
  input  logic [medt_pkg::IDX_OUT_W-1:0] edge_bc_index,
  input  logic                           edge_bc_backward,
  input  logic [medt_pkg::IDX_OUT_W-1:0] edge_ca_index,
  input  logic                           edge_ca_backward,
  output int                             fail_count,
  output int                             pending,
  output int                             tri_count,
  output int                             degen_count,
  output int                             full_count
);
  import medt_pkg::*;

  typedef struct packed {
    logic                 degen;
    logic                 full;
    logic [IDX_OUT_W-1:0] ab_idx;
    logic                 ab_bwd;
    logic [IDX_OUT_W-1:0] bc_idx;
    logic                 bc_bwd;
    logic [IDX_OUT_W-1:0] ca_idx;
    logic                 ca_bwd;
  } tri_result_t;

  // shadow of the point store and the unique edge table
  logic [PT_W-1:0]  shadow_pts [DEF_MAX_POINTS];
  logic [VTX_W-1:0] edge_lo [DEF_MAX_EDGES];
  logic [VTX_W-1:0] edge_hi [DEF_MAX_EDGES];
  int               edge_total;
  tri_result_t      tri_expected [$];

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 30) $display("mismatch: %s", msg);
  endtask

  // order key of a float: bit 32 flags NaN, both zeros map to one key
  function automatic logic [32:0] order_key(input logic [31:0] v);
    logic [32:0] k;
    if (v[30:23] == 8'hFF && v[22:0] != 23'd0) k = {1'b1, 32'd0};
    else if (v[30:0] == 31'd0) k = {1'b0, 32'h8000_0000};
    else if (v[31]) k = {1'b0, ~v};
    else k = {1'b0, v | 32'h8000_0000};
    return k;
  endfunction

  function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] ka, kb;
    ka = order_key(a);
    kb = order_key(b);
    return !ka[32] && !kb[32] && (ka[31:0] > kb[31:0]);
  endfunction

  function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] ka, kb;
    ka = order_key(a);
    kb = order_key(b);
    return !ka[32] && !kb[32] && (ka[31:0] == kb[31:0]);
  endfunction

  // start point stays first unless it is lexicographically greater
  function automatic logic keeps_order(input logic [PT_W-1:0] p, input logic [PT_W-1:0] q);
    if (f_gt(p[95:64], q[95:64])) return 1'b0;
    if (f_eq(p[95:64], q[95:64])) begin
      if (f_gt(p[63:32], q[63:32])) return 1'b0;
      if (f_eq(p[63:32], q[63:32]) && f_gt(p[31:0], q[31:0])) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic lookup_edge(input logic [VTX_W-1:0] s, input logic [VTX_W-1:0] f,
                             output bit hit, output int idx, output bit bwd);
    hit = 0;
    idx = 0;
    bwd = 0;
    for (int i = 0; i < edge_total; i++) begin
      if (edge_lo[i] == s && edge_hi[i] == f) begin
        hit = 1; idx = i; return;
      end
      if (edge_lo[i] == f && edge_hi[i] == s) begin
        hit = 1; idx = i; bwd = 1; return;
      end
    end
  endtask

  task automatic predict_triangle(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                                  input logic [VTX_W-1:0] c, output tri_result_t r);
    logic [VTX_W-1:0] v [3];
    int               idx [3];
    bit               bw [3];
    bit               hit;
    int               missing;
    r = '0;
    v[0] = a;
    v[1] = b;
    v[2] = c;
    missing = 0;
    if (a == b || a == c || b == c) begin
      r.degen = 1'b1;
      return;
    end
    for (int k = 0; k < 3; k++) begin
      lookup_edge(v[k], v[(k + 1) % 3], hit, idx[k], bw[k]);
      if (!hit) missing++;
    end
    if (edge_total + missing > DEF_MAX_EDGES) begin
      r.full = 1'b1;
      return;
    end
    // append in order, later edges may hit ones appended just before
    for (int k = 0; k < 3; k++) begin
      lookup_edge(v[k], v[(k + 1) % 3], hit, idx[k], bw[k]);
      if (!hit) begin
        idx[k] = edge_total;
        if (keeps_order(shadow_pts[v[k]], shadow_pts[v[(k + 1) % 3]])) begin
          edge_lo[edge_total] = v[k];
          edge_hi[edge_total] = v[(k + 1) % 3];
          bw[k] = 0;
        end else begin
          edge_lo[edge_total] = v[(k + 1) % 3];
          edge_hi[edge_total] = v[k];
          bw[k] = 1;
        end
        edge_total++;
      end
    end
    r.ab_idx = idx[0][IDX_OUT_W-1:0];
    r.ab_bwd = bw[0];
    r.bc_idx = idx[1][IDX_OUT_W-1:0];
    r.bc_bwd = bw[1];
    r.ca_idx = idx[2][IDX_OUT_W-1:0];
    r.ca_bwd = bw[2];
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    tri_count = 0;
    degen_count = 0;
    full_count = 0;
    edge_total = 0;
  end

  always @(posedge clk) begin
    tri_result_t r;
    if (rst) begin
      tri_expected.delete();
      edge_total = 0;
    end else begin
      // input beat
      if (in_valid && in_ready) begin
        case (mode)
          MODE_POINT: shadow_pts[point_slot] = {coord_x, coord_y, coord_z};
          MODE_CLEAR: edge_total = 0;
          MODE_TRI: begin
            predict_triangle(vertex_a, vertex_b, vertex_c, r);
            tri_expected = {tri_expected, r};
            tri_count++;
            if (r.degen) degen_count++;
            if (r.full) full_count++;
          end
          default: ;
        endcase
      end
      // result beat
      if (out_valid && out_ready) begin
        if (tri_expected.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          r = tri_expected.pop_front();
          check_field("degenerate", degenerate, r.degen);
          check_field("table_full", table_full, r.full);
          check_field("edge_ab_index", edge_ab_index, r.ab_idx);
          check_field("edge_ab_backward", edge_ab_backward, r.ab_bwd);
          check_field("edge_bc_index", edge_bc_index, r.bc_idx);
          check_field("edge_bc_backward", edge_bc_backward, r.bc_bwd);
          check_field("edge_ca_index", edge_ca_index, r.ca_idx);
          check_field("edge_ca_backward", edge_ca_backward, r.ca_bwd);
        end
      end
    end
    pending = tri_expected.size();
  end

endmodule

/* tb/sv/tb.sv */
// testbench top for the mesh edge dedup table: stimulus, receiver stalls and verdict
module tb;
  import medt_pkg::*;

  // mode code that the block drops without a result
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    mode = MODE_POINT;
  logic [VTX_W-1:0]     point_slot = '0;
  logic [COORD_W-1:0]   coord_x = '0;
  logic [COORD_W-1:0]   coord_y = '0;
  logic [COORD_W-1:0]   coord_z = '0;
  logic [VTX_W-1:0]     vertex_a = '0;
  logic [VTX_W-1:0]     vertex_b = '0;
  logic [VTX_W-1:0]     vertex_c = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 degenerate;
  logic                 table_full;
  logic [IDX_OUT_W-1:0] edge_ab_index;
  logic                 edge_ab_backward;
  logic [IDX_OUT_W-1:0] edge_bc_index;
  logic                 edge_bc_backward;
  logic [IDX_OUT_W-1:0] edge_ca_index;
  logic                 edge_ca_backward;

  int fail_count, pending, tri_count, degen_count, full_count;

  // sender burst state and written slot bookkeeping
  int burst_left = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_cnt = 0;
  int rx_style = 0;
  int rx_phase = 0;
  int written [$];
  bit is_written [DEF_MAX_POINTS];

  mesh_edge_dedup_table_unit dut (.*);

  medt_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: stall style drawn at random from three styles, long hold on request
  always @(negedge clk) begin
    rx_phase++;
    if (rx_phase % 80 == 0) rx_style = $urandom_range(0, 2);
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready = 1'b0;
    end else if (rx_style == 0) begin
      out_ready = 1'b1;
    end else if (rx_style == 1) begin
      out_ready = ($urandom_range(0, 3) != 0);
    end else begin
      out_ready = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("tb NOT OK");
    $finish;
  end

  // one beat, called at a falling edge, returns at a falling edge
  task automatic send(input logic [MODE_W-1:0] m, input int slot, input logic [31:0] x,
                      input logic [31:0] y, input logic [31:0] z,
                      input int a, input int b, input int c);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
    end
    burst_left--;
    mode = m;
    point_slot = VTX_W'(slot);
    coord_x = x;
    coord_y = y;
    coord_z = z;
    vertex_a = VTX_W'(a);
    vertex_b = VTX_W'(b);
    vertex_c = VTX_W'(c);
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_point(input int slot, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    send(MODE_POINT, slot, x, y, z, $urandom, $urandom, $urandom);
    if (!is_written[slot]) begin
      is_written[slot] = 1;
      written = {written, slot};
    end
  endtask

  task automatic triangle(input int a, input int b, input int c);
    send(MODE_TRI, $urandom, $urandom, $urandom, $urandom, a, b, c);
  endtask

  // coordinates lean on specials and a few repeats so ties reach y and z
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0001;
      5, 6: return {$urandom_range(0, 1) ? 8'hBF : 8'h3F, 8'h80, 16'h0000}
                   + ($urandom_range(0, 3) << 20);
      default: return $urandom;
    endcase
  endfunction

  // written vertex, mostly from the first few slots so edges repeat
  function automatic int pick_vertex();
    int lim;
    lim = ($urandom_range(0, 7) == 0) ? written.size() : 16;
    if (lim > written.size()) lim = written.size();
    return written[$urandom_range(0, lim - 1)];
  endfunction

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    int a, b, c, r, slot, guard;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: signed zeros, infinities, NaN, ties on x and y, extreme slots
    write_point(0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    write_point(1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    write_point(1, 32'h3F80_0000, 32'h7F80_0000, 32'h0000_0000);
    write_point(2, 32'h7FC0_0000, 32'h0000_0000, 32'h3F80_0000);
    write_point(3, 32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000);
    write_point(4, 32'h3F80_0000, 32'hBF80_0000, 32'hC000_0000);
    write_point(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_point(512, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h0000_0001);
    triangle(0, 1023, 1);
    triangle(1023, 0, 1);
    triangle(3, 4, 0);
    triangle(4, 3, 2);
    triangle(1, 5, 512);
    triangle(3, 3, 4);
    triangle(3, 4, 4);
    triangle(5, 4, 5);
    send(MODE_UNUSED, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1023, 1023, 1023);
    send(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    triangle(0, 1, 2);
    triangle(512, 1023, 1);
    triangle(2, 1, 0);

    // random mix of writes, triangles, clears and dropped beats
    for (int i = 0; i < 620; i++) begin
      if (i == 250) hold_asks++;
      if (i == 500) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 28) begin
        slot = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : written[0 +
               $urandom_range(0, (written.size() < 16 ? written.size() : 16) - 1)];
        write_point(slot, pick_coord(), pick_coord(), pick_coord());
      end else if (r < 90) begin
        a = pick_vertex();
        b = pick_vertex();
        c = pick_vertex();
        triangle(a, b, c);
      end else if (r < 94) begin
        send(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom);
      end else begin
        send(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom);
      end
    end

    // fresh table over a small point set so edges are shared between triangles
    wait_drained();
    for (int s = 0; s < 32; s++) write_point(s, pick_coord(), pick_coord(), pick_coord());
    send(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    for (int t = 0; t < 100; t++) begin
      a = $urandom_range(0, 31);
      do b = $urandom_range(0, 31); while (b == a);
      do c = $urandom_range(0, 31); while (c == a || c == b);
      triangle(a, b, c);
    end
    triangle(7, 9, 7);
    send(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    triangle(10, 11, 12);
    triangle(12, 11, 10);

    // drain and verdict
    guard = 0;
    while (pending != 0 && guard < 200_000) begin
      @(negedge clk);
      guard++;
    end
    repeat (50) @(negedge clk);
    $display("covered %0d triangles: %0d degenerate, %0d refused on a full table",
             tri_count, degen_count, full_count);
    $display("unmatched expectations at end: %0d, mismatches: %0d", pending, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
